### hdl/stt_pkg.sv
// ---------------------------------------------------------------------------
// Tokeniser package
// Shared types, token kinds, character constants and the punctuation table.
// ---------------------------------------------------------------------------
package stt_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [4:0] KIND_NUMBER  = 5'd0;
	localparam logic [4:0] KIND_STRING  = 5'd1;
	localparam logic [4:0] KIND_EQ      = 5'd2;
	localparam logic [4:0] KIND_COLON   = 5'd3;
	localparam logic [4:0] KIND_COMMA   = 5'd4;
	localparam logic [4:0] KIND_SEMI    = 5'd5;
	localparam logic [4:0] KIND_LPAREN  = 5'd6;
	localparam logic [4:0] KIND_RPAREN  = 5'd7;
	localparam logic [4:0] KIND_LBRACE  = 5'd8;
	localparam logic [4:0] KIND_RBRACE  = 5'd9;
	localparam logic [4:0] KIND_PLUS    = 5'd10;
	localparam logic [4:0] KIND_MINUS   = 5'd11;
	localparam logic [4:0] KIND_STAR    = 5'd12;
	localparam logic [4:0] KIND_SLASH   = 5'd13;
	localparam logic [4:0] KIND_END     = 5'd14;
	localparam logic [4:0] KIND_IDENT   = 5'd15;
	localparam logic [4:0] KIND_UNKNOWN = 5'd16;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef enum logic [3:0] {
		MODE_IDLE   = 4'b0001,
		MODE_NUMBER = 4'b0010,
		MODE_IDENT  = 4'b0100,
		MODE_STRING = 4'b1000
	} scan_mode_t;

	typedef struct packed {
		logic [4:0] token_kind;
		logic [7:0] text_byte;
		logic       text_present;
		logic       first_of_token;
		logic       last_of_token;
	} res_t;

	// Up to two results caused by one input byte; slot a is used first.
	typedef struct packed {
		logic a_valid;
		res_t a;
		logic b_valid;
		res_t b;
	} entry_t;

	typedef struct packed {
		logic hit;
		logic [4:0] kind;
	} punct_t;

	function automatic punct_t punct_lookup(input logic [7:0] c);
		punct_t p;
		p.hit = 1'b1;
		case (c)
			CH_EQ:     p.kind = KIND_EQ;
			CH_COLON:  p.kind = KIND_COLON;
			CH_COMMA:  p.kind = KIND_COMMA;
			CH_SEMI:   p.kind = KIND_SEMI;
			CH_LPAREN: p.kind = KIND_LPAREN;
			CH_RPAREN: p.kind = KIND_RPAREN;
			CH_LBRACE: p.kind = KIND_LBRACE;
			CH_RBRACE: p.kind = KIND_RBRACE;
			CH_PLUS:   p.kind = KIND_PLUS;
			CH_MINUS:  p.kind = KIND_MINUS;
			CH_STAR:   p.kind = KIND_STAR;
			CH_SLASH:  p.kind = KIND_SLASH;
			default: begin
				p.hit  = 1'b0;
				p.kind = KIND_UNKNOWN;
			end
		endcase
		return p;
	endfunction

endpackage

### hdl/stt_if.sv
// ---------------------------------------------------------------------------
// Tokeniser channels
// Valid/ready channels for source bytes and for token result beats.
// ---------------------------------------------------------------------------
interface stt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_byte;

	modport source (output valid, output char_byte, input ready);
	modport sink   (input valid, input char_byte, output ready);
endinterface

interface stt_token_if;
	logic       valid;
	logic       ready;
	logic [4:0] token_kind;
	logic [7:0] text_byte;
	logic       text_present;
	logic       first_of_token;
	logic       last_of_token;

	modport source (output valid, output token_kind, output text_byte, output text_present,
		output first_of_token, output last_of_token, input ready);
	modport sink   (input valid, input token_kind, input text_byte, input text_present,
		input first_of_token, input last_of_token, output ready);
endinterface

### hdl/stt_front.sv
// ---------------------------------------------------------------------------
// Tokeniser front end
// Classifies each byte, keeps the scan state and the held-back byte, and
// forms the results that the byte causes as one queue entry.
// ---------------------------------------------------------------------------
module stt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_byte,
	output logic              push,
	output stt_pkg::entry_t   entry
);

	stt_pkg::scan_mode_t mode_q, mode_nxt;
	logic       held_valid_q, held_valid_nxt;
	logic [7:0] held_byte_q, held_byte_nxt;
	logic       held_first_q, held_first_nxt;

	logic            is_dig, is_let, cont, start_en;
	logic [4:0]      held_kind;
	stt_pkg::res_t   a_r, b_r;
	logic            a_v, b_v;
	stt_pkg::punct_t pl;

	always_comb begin
		is_dig = (char_byte >= stt_pkg::CH_0) && (char_byte <= stt_pkg::CH_9);
		is_let = ((char_byte >= stt_pkg::CH_LC_A) && (char_byte <= stt_pkg::CH_LC_Z)) ||
			((char_byte >= stt_pkg::CH_UC_A) && (char_byte <= stt_pkg::CH_UC_Z));
		pl = stt_pkg::punct_lookup(char_byte);

		case (mode_q)
			stt_pkg::MODE_NUMBER: held_kind = stt_pkg::KIND_NUMBER;
			stt_pkg::MODE_IDENT:  held_kind = stt_pkg::KIND_IDENT;
			default:              held_kind = stt_pkg::KIND_STRING;
		endcase

		case (mode_q)
			stt_pkg::MODE_NUMBER: cont = is_dig || (char_byte == stt_pkg::CH_DOT);
			stt_pkg::MODE_IDENT:  cont = is_dig || is_let;
			stt_pkg::MODE_STRING: cont = (char_byte != stt_pkg::CH_QUOTE) &&
				(char_byte != stt_pkg::CH_NUL);
			default:              cont = 1'b0;
		endcase

		a_v            = 1'b0;
		a_r            = '0;
		b_v            = 1'b0;
		b_r            = '0;
		start_en       = 1'b0;
		mode_nxt       = mode_q;
		held_valid_nxt = held_valid_q;
		held_byte_nxt  = held_byte_q;
		held_first_nxt = held_first_q;

		if (mode_q == stt_pkg::MODE_IDLE) begin
			start_en = 1'b1;
		end else if (cont) begin
			// Token goes on: the held byte leaves as an inner beat.
			if (held_valid_q) begin
				a_v = 1'b1;
				a_r = '{held_kind, held_byte_q, 1'b1, held_first_q, 1'b0};
			end
			held_first_nxt = !held_valid_q;
			held_valid_nxt = 1'b1;
			held_byte_nxt  = char_byte;
		end else begin
			// Token ends: the held byte, or an empty string, closes it.
			if (held_valid_q) begin
				a_v = 1'b1;
				a_r = '{held_kind, held_byte_q, 1'b1, held_first_q, 1'b1};
			end else if (mode_q == stt_pkg::MODE_STRING) begin
				a_v = 1'b1;
				a_r = '{stt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1};
			end
			mode_nxt       = stt_pkg::MODE_IDLE;
			held_valid_nxt = 1'b0;
			held_byte_nxt  = 8'h00;
			held_first_nxt = 1'b0;
			// A closing quote is consumed; anything else starts afresh.
			start_en = !((mode_q == stt_pkg::MODE_STRING) && (char_byte == stt_pkg::CH_QUOTE));
		end

		if (start_en) begin
			if ((char_byte == stt_pkg::CH_SPACE) || (char_byte == stt_pkg::CH_NL)) begin
				b_v = 1'b0;
			end else if (char_byte == stt_pkg::CH_NUL) begin
				b_v = 1'b1;
				b_r = '{stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1};
			end else if (is_dig || is_let) begin
				mode_nxt       = is_dig ? stt_pkg::MODE_NUMBER : stt_pkg::MODE_IDENT;
				held_valid_nxt = 1'b1;
				held_byte_nxt  = char_byte;
				held_first_nxt = 1'b1;
			end else if (char_byte == stt_pkg::CH_QUOTE) begin
				mode_nxt       = stt_pkg::MODE_STRING;
				held_valid_nxt = 1'b0;
				held_first_nxt = 1'b0;
			end else begin
				b_v = 1'b1;
				b_r = '{pl.kind, char_byte, 1'b1, 1'b1, 1'b1};
			end
		end

		if (a_v) begin
			entry = '{1'b1, a_r, b_v, b_r};
		end else begin
			entry = '{b_v, b_r, 1'b0, stt_pkg::res_t'('0)};
		end
		push = accept && (a_v || b_v);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= stt_pkg::MODE_IDLE;
			held_valid_q <= 1'b0;
			held_byte_q  <= 8'h00;
			held_first_q <= 1'b0;
		end else if (accept) begin
			mode_q       <= mode_nxt;
			held_valid_q <= held_valid_nxt;
			held_byte_q  <= held_byte_nxt;
			held_first_q <= held_first_nxt;
		end
	end

	// A byte can only be held back inside a number, identifier or string.
	a_held_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> (mode_q != stt_pkg::MODE_IDLE))
		else $error("held byte outside a token");

endmodule

### hdl/stt_queue.sv
// ---------------------------------------------------------------------------
// Tokeniser entry queue
// Short first-in first-out queue between the front end and the back end.
// ---------------------------------------------------------------------------
module stt_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  stt_pkg::entry_t push_entry,
	input  logic            pop,
	output stt_pkg::entry_t pop_entry,
	output logic            full,
	output logic            empty
);

	stt_pkg::entry_t                slot_q [stt_pkg::QUEUE_DEPTH];
	logic [stt_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [stt_pkg::QCNT_W-1:0]     count_q;

	localparam logic [stt_pkg::QPTR_W-1:0] PTR_LAST = stt_pkg::QPTR_W'(stt_pkg::QUEUE_DEPTH - 1);
	localparam logic [stt_pkg::QCNT_W-1:0] CNT_FULL = stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH);

	assign full      = (count_q == CNT_FULL);
	assign empty     = (count_q == '0);
	assign pop_entry = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("queue read while empty");

endmodule

### hdl/stt_back.sv
// ---------------------------------------------------------------------------
// Tokeniser back end
// Takes queue entries and sends their one or two results out as beats
// through an output register.
// ---------------------------------------------------------------------------
module stt_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  stt_pkg::entry_t     head,
	output logic                pop,
	stt_token_if.source         tokens
);

	logic          out_valid_q;
	stt_pkg::res_t out_q;
	logic          pend_valid_q;
	stt_pkg::res_t pend_q;
	logic          out_free;

	assign out_free = !out_valid_q || tokens.ready;
	assign pop      = out_free && !pend_valid_q && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!empty) begin
				out_valid_q  <= head.a_valid;
				pend_valid_q <= head.b_valid;
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (!empty) begin
				out_q  <= head.a;
				pend_q <= head.b;
			end
		end
	end

	assign tokens.valid          = out_valid_q;
	assign tokens.token_kind     = out_q.token_kind;
	assign tokens.text_byte      = out_q.text_byte;
	assign tokens.text_present   = out_q.text_present;
	assign tokens.first_of_token = out_q.first_of_token;
	assign tokens.last_of_token  = out_q.last_of_token;

	// The second result of an entry waits behind a first one in the output register.
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q)
		else $error("second result pending with no first result shown");

endmodule

### hdl/source_text_tokenizer.sv
// Source text tokeniser: source bytes enter on the chars channel, one per cycle while
// the queue is not full, and every accepted byte is classified in the cycle it arrives.
// The front end keeps one byte of a number, identifier or string held back until the
// next byte shows whether the token has ended; a byte causes zero, one or two result
// beats, and they are queued as one entry in a four-deep queue. The back end sends one
// beat per cycle from its output register while the token channel is ready, so the
// block takes a byte every cycle while the byte stream yields no more than one beat per
// byte and the token channel stays ready; a byte that both closes a token and yields a
// one-character token gives the back end two beats; the queue absorbs bursts of those.
// ---------------------------------------------------------------------------
// Source text tokeniser top level
// Front end, entry queue and back end joined by valid/ready channels.
// ---------------------------------------------------------------------------
module source_text_tokenizer (
	input  logic         clk,
	input  logic         arst_n,
	stt_byte_if.sink     chars,
	stt_token_if.source  tokens
);

	logic            accept, push, pop, full, empty;
	stt_pkg::entry_t push_entry, head;

	assign chars.ready = !full;
	assign accept      = chars.valid && !full;

	stt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.char_byte (chars.char_byte),
		.push      (push),
		.entry     (push_entry)
	);

	stt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (head),
		.full       (full),
		.empty      (empty)
	);

	stt_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.tokens (tokens)
	);

endmodule

### test/source_text_tokenizer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Source text tokeniser testbench
// Feeds directed and randomly built source text through the byte channel,
// predicts every token beat in a scoreboard and checks the beats that leave
// the token channel, with random idling on both channels.
// ---------------------------------------------------------------------------
module source_text_tokenizer_test;

	class token_scoreboard;
		stt_pkg::scan_mode_t mode;
		bit                  held_valid;
		logic [7:0]          held_byte;
		bit                  held_first;
		stt_pkg::res_t       pending_beats[$];
		int                  errors;

		function new();
			mode       = stt_pkg::MODE_IDLE;
			held_valid = 1'b0;
			held_byte  = 8'h00;
			held_first = 1'b0;
			errors     = 0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= stt_pkg::CH_0 && c <= stt_pkg::CH_9;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= stt_pkg::CH_LC_A && c <= stt_pkg::CH_LC_Z) ||
				(c >= stt_pkg::CH_UC_A && c <= stt_pkg::CH_UC_Z);
		endfunction

		function void emit(logic [4:0] kind, logic [7:0] text, bit present, bit first, bit last);
			stt_pkg::res_t r;
			r.token_kind     = kind;
			r.text_byte      = text;
			r.text_present   = present;
			r.first_of_token = first;
			r.last_of_token  = last;
			pending_beats.push_back(r);
		endfunction

		function logic [4:0] held_kind();
			case (mode)
				stt_pkg::MODE_NUMBER: return stt_pkg::KIND_NUMBER;
				stt_pkg::MODE_IDENT:  return stt_pkg::KIND_IDENT;
				default:              return stt_pkg::KIND_STRING;
			endcase
		endfunction

		function logic [4:0] single_kind(logic [7:0] c);
			case (c)
				stt_pkg::CH_EQ:     return stt_pkg::KIND_EQ;
				stt_pkg::CH_COLON:  return stt_pkg::KIND_COLON;
				stt_pkg::CH_COMMA:  return stt_pkg::KIND_COMMA;
				stt_pkg::CH_SEMI:   return stt_pkg::KIND_SEMI;
				stt_pkg::CH_LPAREN: return stt_pkg::KIND_LPAREN;
				stt_pkg::CH_RPAREN: return stt_pkg::KIND_RPAREN;
				stt_pkg::CH_LBRACE: return stt_pkg::KIND_LBRACE;
				stt_pkg::CH_RBRACE: return stt_pkg::KIND_RBRACE;
				stt_pkg::CH_PLUS:   return stt_pkg::KIND_PLUS;
				stt_pkg::CH_MINUS:  return stt_pkg::KIND_MINUS;
				stt_pkg::CH_STAR:   return stt_pkg::KIND_STAR;
				stt_pkg::CH_SLASH:  return stt_pkg::KIND_SLASH;
				default:            return stt_pkg::KIND_UNKNOWN;
			endcase
		endfunction

		// The held byte becomes the last beat; an open string with nothing held is empty.
		function void close_open_token();
			if (held_valid)
				emit(held_kind(), held_byte, 1'b1, held_first, 1'b1);
			else if (mode == stt_pkg::MODE_STRING)
				emit(stt_pkg::KIND_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
			mode       = stt_pkg::MODE_IDLE;
			held_valid = 1'b0;
			held_byte  = 8'h00;
			held_first = 1'b0;
		endfunction

		function void shift_held(logic [7:0] c);
			if (held_valid) begin
				emit(held_kind(), held_byte, 1'b1, held_first, 1'b0);
				held_first = 1'b0;
			end else begin
				held_first = 1'b1;
			end
			held_valid = 1'b1;
			held_byte  = c;
		endfunction

		function void start_token(logic [7:0] c);
			if (c == stt_pkg::CH_SPACE || c == stt_pkg::CH_NL)
				return;
			if (c == stt_pkg::CH_NUL) begin
				emit(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
			end else if (is_digit(c) || is_letter(c)) begin
				mode       = is_digit(c) ? stt_pkg::MODE_NUMBER : stt_pkg::MODE_IDENT;
				held_valid = 1'b1;
				held_byte  = c;
				held_first = 1'b1;
			end else if (c == stt_pkg::CH_QUOTE) begin
				mode       = stt_pkg::MODE_STRING;
				held_valid = 1'b0;
				held_first = 1'b0;
			end else begin
				emit(single_kind(c), c, 1'b1, 1'b1, 1'b1);
			end
		endfunction

		function void note_byte(logic [7:0] c);
			case (mode)
				stt_pkg::MODE_NUMBER: begin
					if (is_digit(c) || c == stt_pkg::CH_DOT) begin
						shift_held(c);
					end else begin
						close_open_token();
						start_token(c);
					end
				end
				stt_pkg::MODE_IDENT: begin
					if (is_digit(c) || is_letter(c)) begin
						shift_held(c);
					end else begin
						close_open_token();
						start_token(c);
					end
				end
				stt_pkg::MODE_STRING: begin
					if (c == stt_pkg::CH_QUOTE) begin
						close_open_token();
					end else if (c == stt_pkg::CH_NUL) begin
						close_open_token();
						emit(stt_pkg::KIND_END, 8'h00, 1'b0, 1'b1, 1'b1);
					end else begin
						shift_held(c);
					end
				end
				default: start_token(c);
			endcase
		endfunction

		function void check_beat(stt_pkg::res_t got);
			stt_pkg::res_t want;
			if (pending_beats.size() == 0) begin
				$error("token beat with nothing expected: kind %0d, byte 0x%02h",
					got.token_kind, got.text_byte);
				errors++;
				return;
			end
			want = pending_beats.pop_front();
			if (got.token_kind !== want.token_kind) begin
				$error("token_kind: expected %0d, actual %0d", want.token_kind, got.token_kind);
				errors++;
			end
			if (got.text_byte !== want.text_byte) begin
				$error("text_byte: expected 0x%02h, actual 0x%02h", want.text_byte, got.text_byte);
				errors++;
			end
			if (got.text_present !== want.text_present) begin
				$error("text_present: expected %0b, actual %0b",
					want.text_present, got.text_present);
				errors++;
			end
			if (got.first_of_token !== want.first_of_token) begin
				$error("first_of_token: expected %0b, actual %0b",
					want.first_of_token, got.first_of_token);
				errors++;
			end
			if (got.last_of_token !== want.last_of_token) begin
				$error("last_of_token: expected %0b, actual %0b",
					want.last_of_token, got.last_of_token);
				errors++;
			end
		endfunction

		function int outstanding();
			return pending_beats.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	stt_byte_if  chars ();
	stt_token_if tokens ();

	source_text_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars),
		.tokens (tokens)
	);

	token_scoreboard board = new();

	int tx_idle_pct = 23;
	int rx_idle_pct = 45;
	int sent_bytes  = 0;

	logic [7:0] punct_bytes [12] = '{stt_pkg::CH_EQ, stt_pkg::CH_COLON, stt_pkg::CH_COMMA,
		stt_pkg::CH_SEMI, stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE,
		stt_pkg::CH_RBRACE, stt_pkg::CH_PLUS, stt_pkg::CH_MINUS, stt_pkg::CH_STAR,
		stt_pkg::CH_SLASH};

	// Every punctuation mark, an empty string, a number running into an identifier
	// closed by a stray top byte, skipped blanks, an empty string and a string with
	// text both left open at end of text, and a number closed by end of text.
	logic [7:0] opening_text [28] = '{stt_pkg::CH_EQ, stt_pkg::CH_COLON, stt_pkg::CH_COMMA,
		stt_pkg::CH_SEMI, stt_pkg::CH_LPAREN, stt_pkg::CH_RPAREN, stt_pkg::CH_LBRACE,
		stt_pkg::CH_RBRACE, stt_pkg::CH_PLUS, stt_pkg::CH_MINUS, stt_pkg::CH_STAR,
		stt_pkg::CH_SLASH, stt_pkg::CH_QUOTE, stt_pkg::CH_QUOTE, stt_pkg::CH_9,
		stt_pkg::CH_DOT, stt_pkg::CH_LC_Z, stt_pkg::CH_UC_A, 8'hFF, stt_pkg::CH_SPACE,
		stt_pkg::CH_NL, stt_pkg::CH_QUOTE, stt_pkg::CH_NUL, stt_pkg::CH_QUOTE,
		stt_pkg::CH_NL, stt_pkg::CH_NUL, stt_pkg::CH_0, stt_pkg::CH_NUL};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		tokens.ready = 1'b0;
		forever begin
			@(negedge clk);
			tokens.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && tokens.valid && tokens.ready)
			board.check_beat(stt_pkg::res_t'({tokens.token_kind, tokens.text_byte,
				tokens.text_present, tokens.first_of_token, tokens.last_of_token}));
	end

	task automatic send_byte(input logic [7:0] c);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			chars.valid <= 1'b0;
			@(negedge clk);
		end
		chars.valid     <= 1'b1;
		chars.char_byte <= c;
		do @(posedge clk); while (!chars.ready);
		board.note_byte(c);
		sent_bytes++;
	endtask

	task automatic send_letter();
		if ($urandom_range(1))
			send_byte(8'(stt_pkg::CH_UC_A + $urandom_range(25)));
		else
			send_byte(8'(stt_pkg::CH_LC_A + $urandom_range(25)));
	endtask

	// Mostly well-formed tokens with random content, with some noise mixed in.
	task automatic send_random_token();
		int pick;
		int len;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (pick < 22) begin
			len = $urandom_range(1, 6);
			send_byte(8'(stt_pkg::CH_0 + $urandom_range(9)));
			repeat (len - 1) begin
				if ($urandom_range(3) == 0)
					send_byte(stt_pkg::CH_DOT);
				else
					send_byte(8'(stt_pkg::CH_0 + $urandom_range(9)));
			end
		end else if (pick < 44) begin
			len = $urandom_range(1, 6);
			send_letter();
			repeat (len - 1) begin
				if ($urandom_range(2) == 0)
					send_byte(8'(stt_pkg::CH_0 + $urandom_range(9)));
				else
					send_letter();
			end
		end else if (pick < 60) begin
			len = $urandom_range(0, 5);
			send_byte(stt_pkg::CH_QUOTE);
			repeat (len) begin
				do c = 8'($urandom_range(1, 255)); while (c == stt_pkg::CH_QUOTE);
				send_byte(c);
			end
			// Now and then the string is left open and closed by end of text.
			send_byte(($urandom_range(19) == 0) ? stt_pkg::CH_NUL : stt_pkg::CH_QUOTE);
		end else if (pick < 75) begin
			send_byte(punct_bytes[$urandom_range(11)]);
		end else if (pick < 85) begin
			send_byte($urandom_range(1) ? stt_pkg::CH_SPACE : stt_pkg::CH_NL);
		end else if (pick < 90) begin
			send_byte(stt_pkg::CH_NUL);
		end else begin
			send_byte(8'($urandom_range(255)));
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		chars.valid     = 1'b0;
		chars.char_byte = 8'h00;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_text[i])
			send_byte(opening_text[i]);
		while (sent_bytes < 540)
			send_random_token();

		tx_idle_pct = 45;
		rx_idle_pct = 23;
		while (sent_bytes < 1050)
			send_random_token();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		while (sent_bytes < 1550)
			send_random_token();
		send_byte(stt_pkg::CH_NUL);

		@(negedge clk);
		chars.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (board.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
